// ----- hdl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

  // full scale of one 8-bit component and its square
  localparam logic [7:0]  FULL_SCALE  = 8'd255;
  localparam logic [15:0] FULL_SQUARE = 16'd65025;

  // six-times hue thresholds that open sectors 1..5
  localparam logic [10:0] SEC1_LO = 11'd255;
  localparam logic [10:0] SEC2_LO = 11'd510;
  localparam logic [10:0] SEC3_LO = 11'd765;
  localparam logic [10:0] SEC4_LO = 11'd1020;
  localparam logic [10:0] SEC5_LO = 11'd1275;

  // hue sectors of the color wheel
  localparam logic [2:0] SEC_RED_YEL   = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
  localparam logic [2:0] SEC_GRN_CYAN  = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAG  = 3'd4;
  localparam logic [2:0] SEC_MAG_RED   = 3'd5;

  // reciprocal multipliers for exact floor(x / 255)
  // up to 16-bit x: (x * 0x8081) >> 23, up to 32-bit x: (x * 0x80808081) >> 39
  localparam logic [15:0] DIV255_M16   = 16'h8081;
  localparam int unsigned DIV255_SH16  = 23;
  localparam logic [31:0] DIV255_M32   = 32'h80808081;
  localparam int unsigned DIV255_SH32  = 39;

  // widest dividend: brightness times a 16-bit product term
  localparam int unsigned PROD_W = 24;
  // pipeline depth in register stages
  localparam int unsigned STAGES = 6;

endpackage

// ----- hdl/hsv2rgb_div255.sv -----
// Registered exact divide by 255, by reciprocal multiply and shift.
module hsv2rgb_div255
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned W = PROD_W
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] x,
  output logic [W-8:0] q_r
);

  logic [W-8:0] q_nxt;

  generate
    if (W <= 16) begin : g_narrow
      logic [W+15:0] prod;
      assign prod  = (W+16)'(x) * (W+16)'(DIV255_M16);
      assign q_nxt = prod[W+15:DIV255_SH16];
    end else begin : g_wide
      logic [W+31:0] prod;
      assign prod  = (W+32)'(x) * (W+32)'(DIV255_M32);
      assign q_nxt = prod[W+31:DIV255_SH32];
    end
  endgenerate

  // quotient register, held while the stage stalls
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ----- hdl/hsv_to_rgb_pixel.sv -----
// HSV to RGB pixel converter, 8 bits per component. Takes one word per clock while
// in_ready is high and gives its red, green and blue result, the truncated exact value
// of the six-sector hue wheel (hue 255 wraps to 0, zero saturation gives grey).
// The six register stages are: hue sector and fraction, the product terms, the
// brightness multiplies, and two exact divide-by-255 steps, then the sector
// select into the output register. Each stage holds its own valid bit and fills
// bubbles on its own, so in_ready drops only when all six stages hold words and
// out_ready is low; sustained rate is one word per cycle while out_ready stays high.
module hsv_to_rgb_pixel
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  // valid chain and per-stage advance
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] adv;

  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[STAGES-1];

  // stage 1: wrap hue, split 6*hue into sector and fraction
  logic [7:0]  hue_w;
  logic [10:0] h6;
  logic [2:0]  sec1_nxt, sec1_r;
  logic [10:0] frac_full;
  logic [7:0]  frac1_r, s1_r, v1_r;

  assign hue_w = (in_hue == FULL_SCALE) ? 8'd0 : in_hue;
  assign h6    = {1'b0, hue_w, 2'b00} + {2'b00, hue_w, 1'b0};

  always_comb begin
    if (h6 >= SEC5_LO) begin
      sec1_nxt  = SEC_MAG_RED;
      frac_full = h6 - SEC5_LO;
    end else if (h6 >= SEC4_LO) begin
      sec1_nxt  = SEC_BLUE_MAG;
      frac_full = h6 - SEC4_LO;
    end else if (h6 >= SEC3_LO) begin
      sec1_nxt  = SEC_CYAN_BLUE;
      frac_full = h6 - SEC3_LO;
    end else if (h6 >= SEC2_LO) begin
      sec1_nxt  = SEC_GRN_CYAN;
      frac_full = h6 - SEC2_LO;
    end else if (h6 >= SEC1_LO) begin
      sec1_nxt  = SEC_YEL_GRN;
      frac_full = h6 - SEC1_LO;
    end else begin
      sec1_nxt  = SEC_RED_YEL;
      frac_full = h6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sec1_r  <= sec1_nxt;
      frac1_r <= frac_full[7:0];
      s1_r    <= in_saturation;
      v1_r    <= in_brightness;
    end
  end

  // stage 2: q, t and p numerator terms
  logic [15:0] qn2_r, tn2_r, pn2_r;
  logic [2:0]  sec2_r;
  logic [7:0]  v2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      qn2_r  <= FULL_SQUARE - (16'(s1_r) * 16'(frac1_r));
      tn2_r  <= FULL_SQUARE - (16'(s1_r) * 16'(FULL_SCALE - frac1_r));
      pn2_r  <= 16'(v1_r) * 16'(FULL_SCALE - s1_r);
      sec2_r <= sec1_r;
      v2_r   <= v1_r;
    end
  end

  // stage 3: scale q and t terms by brightness
  logic [PROD_W-1:0] qx3_r, tx3_r;
  logic [15:0]       pn3_r;
  logic [2:0]        sec3_r;
  logic [7:0]        v3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      qx3_r  <= PROD_W'(v2_r) * PROD_W'(qn2_r);
      tx3_r  <= PROD_W'(v2_r) * PROD_W'(tn2_r);
      pn3_r  <= pn2_r;
      sec3_r <= sec2_r;
      v3_r   <= v2_r;
    end
  end

  // stage 4: first divide by 255 on q and t, the only one on p
  logic [PROD_W-8:0] qa4, ta4;
  logic [8:0]        p4;
  logic [2:0]        sec4_r;
  logic [7:0]        v4_r;

  hsv2rgb_div255 #(.W(PROD_W)) u_div_q1 (
    .clk (clk), .en (adv[3]), .x (qx3_r), .q_r (qa4)
  );
  hsv2rgb_div255 #(.W(PROD_W)) u_div_t1 (
    .clk (clk), .en (adv[3]), .x (tx3_r), .q_r (ta4)
  );
  hsv2rgb_div255 #(.W(16)) u_div_p (
    .clk (clk), .en (adv[3]), .x (pn3_r), .q_r (p4)
  );

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sec4_r <= sec3_r;
      v4_r   <= v3_r;
    end
  end

  // stage 5: second divide by 255 on q and t
  logic [8:0] q5, t5;
  logic [7:0] p5_r, v5_r;
  logic [2:0] sec5_r;

  hsv2rgb_div255 #(.W(16)) u_div_q2 (
    .clk (clk), .en (adv[4]), .x (qa4[15:0]), .q_r (q5)
  );
  hsv2rgb_div255 #(.W(16)) u_div_t2 (
    .clk (clk), .en (adv[4]), .x (ta4[15:0]), .q_r (t5)
  );

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      p5_r   <= p4[7:0];
      v5_r   <= v4_r;
      sec5_r <= sec4_r;
    end
  end

  // stage 6: sector table into the output register
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] red_r, green_r, blue_r;

  always_comb begin
    unique case (sec5_r)
      SEC_RED_YEL:   begin red_nxt = v5_r;     green_nxt = t5[7:0];  blue_nxt = p5_r;     end
      SEC_YEL_GRN:   begin red_nxt = q5[7:0];  green_nxt = v5_r;     blue_nxt = p5_r;     end
      SEC_GRN_CYAN:  begin red_nxt = p5_r;     green_nxt = v5_r;     blue_nxt = t5[7:0];  end
      SEC_CYAN_BLUE: begin red_nxt = p5_r;     green_nxt = q5[7:0];  blue_nxt = v5_r;     end
      SEC_BLUE_MAG:  begin red_nxt = t5[7:0];  green_nxt = p5_r;     blue_nxt = v5_r;     end
      default:       begin red_nxt = v5_r;     green_nxt = p5_r;     blue_nxt = q5[7:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // checks
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input stalled with a free pipeline stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted word missing from first stage");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (sec1_r <= SEC_MAG_RED))
    else $error("hue sector out of range");

  a_terms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (q5 <= 9'(v5_r) && t5 <= 9'(v5_r) && p5_r <= v5_r))
    else $error("color term exceeds brightness");

endmodule

// ----- verif/tb_hsv_to_rgb_pixel.sv -----
`timescale 1ns / 1ps

module tb_hsv_to_rgb_pixel;
  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  localparam int unsigned STALL_LIMIT = 5000;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic [7:0] in_hue        = '0;
  logic [7:0] in_saturation = '0;
  logic [7:0] in_brightness = '0;
  logic       out_ready     = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  rgb_word_t   expected_rgb_q[$];
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  hsv_to_rgb_pixel dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always #2 clk = ~clk;

  // exact truncating six-sector conversion
  function automatic rgb_word_t rgb_from_hsv(input hsv_word_t px);
    logic [31:0] h;
    logic [31:0] s;
    logic [31:0] v;
    logic [31:0] h6;
    logic [31:0] frac;
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] t;
    logic [2:0]  sector;
    rgb_word_t   res;
    h = 32'(px.hue);
    s = 32'(px.sat);
    v = 32'(px.val);
    if (s == 0) begin
      res = '{px.val, px.val, px.val};
    end else begin
      // full turn wraps back to red
      if (h >= 32'(FULL_SCALE)) h = 0;
      h6     = h * 6;
      sector = 3'(h6 / 32'(FULL_SCALE));
      frac   = h6 % 32'(FULL_SCALE);
      p = (v * (32'(FULL_SCALE) - s)) / 32'(FULL_SCALE);
      q = (v * (32'(FULL_SQUARE) - s * frac)) / 32'(FULL_SQUARE);
      t = (v * (32'(FULL_SQUARE) - s * (32'(FULL_SCALE) - frac))) / 32'(FULL_SQUARE);
      case (sector)
        SEC_RED_YEL:   res = '{px.val, t[7:0], p[7:0]};
        SEC_YEL_GRN:   res = '{q[7:0], px.val, p[7:0]};
        SEC_GRN_CYAN:  res = '{p[7:0], px.val, t[7:0]};
        SEC_CYAN_BLUE: res = '{p[7:0], q[7:0], px.val};
        SEC_BLUE_MAG:  res = '{t[7:0], p[7:0], px.val};
        default:       res = '{px.val, p[7:0], q[7:0]};
      endcase
    end
    return res;
  endfunction

  // result sink backpressure
  always @(posedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // scoreboard: check outgoing words, then log incoming ones; plus stall watchdog
  always @(posedge clk) begin
    rgb_word_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rgb_q.size() == 0) begin
        $display("%0t: unexpected word r=%0d g=%0d b=%0d", $time, out_red, out_green,
                 out_blue);
        mismatches++;
      end else begin
        exp_px = expected_rgb_q.pop_front();
        if (out_red !== exp_px.red) begin
          $display("%0t: red mismatch expected %0d actual %0d", $time, exp_px.red, out_red);
          mismatches++;
        end
        if (out_green !== exp_px.green) begin
          $display("%0t: green mismatch expected %0d actual %0d", $time, exp_px.green,
                   out_green);
          mismatches++;
        end
        if (out_blue !== exp_px.blue) begin
          $display("%0t: blue mismatch expected %0d actual %0d", $time, exp_px.blue,
                   out_blue);
          mismatches++;
        end
      end
      words_checked++;
    end
    if (rst_n && in_valid && in_ready)
      expected_rgb_q.insert(expected_rgb_q.size(),
                            rgb_from_hsv('{in_hue, in_saturation, in_brightness}));
    if ((rst_n && in_valid && in_ready) || (rst_n && out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  // drive one word and hold it until taken; starts and ends on a rising edge
  task automatic send_word(input hsv_word_t px);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= px.hue;
    in_saturation <= px.sat;
    in_brightness <= px.val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // stop sending until every word in flight has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_checked != words_sent) @(posedge clk);
  endtask

  // skewed toward extremes so boundary codes show up often
  function automatic logic [7:0] pick_component();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic hsv_word_t random_pixel();
    hsv_word_t px;
    px.hue = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(255));
    px.sat = pick_component();
    px.val = pick_component();
    return px;
  endfunction

  // grey: zero saturation passes brightness to all channels
  task automatic test_grey();
    send_word('{8'd0,   8'd0, 8'd0});
    send_word('{8'd100, 8'd0, 8'd255});
    send_word('{8'd255, 8'd0, 8'd77});
    send_word('{8'd200, 8'd0, 8'd1});
  endtask

  // hue 255 folds onto hue 0
  task automatic test_hue_wrap();
    send_word('{8'd255, 8'd255, 8'd255});
    send_word('{8'd0,   8'd255, 8'd255});
    send_word('{8'd255, 8'd128, 8'd200});
    send_word('{8'd254, 8'd128, 8'd200});
  endtask

  // both sides of sector edges 0/1, 2/3, 4/5 and 5/0, full and partial saturation
  task automatic test_sector_edges();
    logic [7:0] edge_hues[12];
    edge_hues = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127,
                  8'd128, 8'd170, 8'd171, 8'd212, 8'd213, 8'd254};
    foreach (edge_hues[i])
      send_word('{edge_hues[i], (i % 2 == 0) ? 8'd255 : 8'd1, 8'd255});
    send_word('{8'd30,  8'd255, 8'd0});
    send_word('{8'd150, 8'd1,   8'd1});
    send_word('{8'd190, 8'd200, 8'd128});
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_word(random_pixel());
  endtask

  // burst, full drain with the input held off, burst again
  task automatic test_drain_pause();
    test_random(20);
    wait_drained();
    test_random(20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 49;
    test_grey();
    test_hue_wrap();
    test_sector_edges();
    test_random(560);
    test_drain_pause();

    send_idle_pct = 49;
    recv_idle_pct = 21;
    test_random(580);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(580);

    wait_drained();
    repeat (STAGES * 4) @(posedge clk);
    if (mismatches == 0 && expected_rgb_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
